### design/szalu_pkg.sv
// Package for the sized integer ALU: opcodes, width codes, stage structs.
// Shared by every module of the block; no dependencies of its own.
package szalu_pkg;

    localparam int DATA_WIDTH  = 64;
    localparam int HALF_WIDTH  = DATA_WIDTH / 2;
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int FUNC_WIDTH  = 4;
    localparam int WCODE_WIDTH = 2;
    localparam int SHAMT_WIDTH = $clog2(DATA_WIDTH);

    // Input item: func, width_code, src_value, dst_value, padded to bytes
    localparam int IN_BITS     = FUNC_WIDTH + WCODE_WIDTH + 2 * DATA_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    // Result item: result_value, high_part, five single-bit fields
    localparam int OUT_BITS    = 2 * DATA_WIDTH + 5;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Opcodes; codes 12..15 do nothing
    typedef enum logic [FUNC_WIDTH-1:0] {
        OP_MOV = 4'd0,
        OP_ADD = 4'd1,
        OP_CMP = 4'd2,
        OP_SUB = 4'd3,
        OP_MUL = 4'd4,
        OP_NEG = 4'd5,
        OP_AND = 4'd6,
        OP_OR  = 4'd7,
        OP_XOR = 4'd8,
        OP_NOT = 4'd9,
        OP_SHL = 4'd10,
        OP_SHR = 4'd11
    } op_t;

    // Operand width codes
    typedef enum logic [WCODE_WIDTH-1:0] {
        W_8  = 2'd0,
        W_16 = 2'd1,
        W_32 = 2'd2,
        W_64 = 2'd3
    } wcode_t;

    // Operands after width masking
    typedef struct packed {
        logic [FUNC_WIDTH-1:0] func;
        wcode_t                wcode;
        logic [DATA_WIDTH-1:0] src;
        logic [DATA_WIDTH-1:0] dst;
    } opnd_t;

    // First execute stage: plain result plus the four partial products
    typedef struct packed {
        wcode_t                wcode;
        logic                  is_mul;
        logic                  wr;
        logic [DATA_WIDTH-1:0] res;
        logic [DATA_WIDTH-1:0] fsrc;
        logic [DATA_WIDTH-1:0] pp_ll;
        logic [DATA_WIDTH-1:0] pp_lh;
        logic [DATA_WIDTH-1:0] pp_hl;
        logic [DATA_WIDTH-1:0] pp_hh;
    } ex1_t;

    // Second execute stage: final values, flags still to derive
    typedef struct packed {
        wcode_t                wcode;
        logic                  wr;
        logic                  wh;
        logic [DATA_WIDTH-1:0] res;
        logic [DATA_WIDTH-1:0] high;
        logic [DATA_WIDTH-1:0] fsrc;
    } ex2_t;

    // All-ones mask for an operand width
    function automatic logic [DATA_WIDTH-1:0] width_mask(input wcode_t wc);
        logic [DATA_WIDTH-1:0] m;
        unique case (wc)
            W_8:     m = DATA_WIDTH'(8'hFF);
            W_16:    m = DATA_WIDTH'(16'hFFFF);
            W_32:    m = DATA_WIDTH'(32'hFFFF_FFFF);
            default: m = '1;
        endcase
        return m;
    endfunction

endpackage

### design/szalu_ops.sv
// First execute stage: logic, add/sub, shifts and 32x32 partial products.
// Uses szalu_pkg types; operands arrive already masked to the width.
module szalu_ops (
    input  szalu_pkg::opnd_t op_in,
    output szalu_pkg::ex1_t  ex1
);
    import szalu_pkg::*;

    logic [DATA_WIDTH-1:0] m;
    logic [DATA_WIDTH-1:0] s;
    logic [DATA_WIDTH-1:0] d;
    logic [DATA_WIDTH-1:0] diff;
    logic                  big_shift;
    logic [SHAMT_WIDTH-1:0] shamt;
    logic [HALF_WIDTH-1:0] s_lo, s_hi, d_lo, d_hi;

    assign m         = width_mask(op_in.wcode);
    assign s         = op_in.src;
    assign d         = op_in.dst;
    assign diff      = (d - s) & m;
    assign big_shift = |s[DATA_WIDTH-1:SHAMT_WIDTH];
    assign shamt     = s[SHAMT_WIDTH-1:0];

    // Operand halves for the four partial products
    assign s_lo = s[HALF_WIDTH-1:0];
    assign s_hi = s[DATA_WIDTH-1:HALF_WIDTH];
    assign d_lo = d[HALF_WIDTH-1:0];
    assign d_hi = d[DATA_WIDTH-1:HALF_WIDTH];

    always_comb
    begin
        ex1.wcode  = op_in.wcode;
        ex1.is_mul = 1'b0;
        ex1.wr     = 1'b1;
        ex1.res    = '0;
        ex1.pp_ll  = DATA_WIDTH'(s_lo) * DATA_WIDTH'(d_lo);
        ex1.pp_lh  = DATA_WIDTH'(s_lo) * DATA_WIDTH'(d_hi);
        ex1.pp_hl  = DATA_WIDTH'(s_hi) * DATA_WIDTH'(d_lo);
        ex1.pp_hh  = DATA_WIDTH'(s_hi) * DATA_WIDTH'(d_hi);

        unique case (op_t'(op_in.func))
            OP_MOV: ex1.res = s;
            OP_ADD: ex1.res = (d + s) & m;
            OP_CMP: ex1.wr  = 1'b0;
            OP_SUB: ex1.res = diff;
            OP_MUL: ex1.is_mul = 1'b1;
            OP_NEG: ex1.res = ((~d & m) + DATA_WIDTH'(1)) & m;
            OP_AND: ex1.res = s & d;
            OP_OR:  ex1.res = s | d;
            OP_XOR: ex1.res = s ^ d;
            OP_NOT: ex1.res = ~d & m;
            OP_SHL: ex1.res = big_shift ? '0 : ((d << shamt) & m);
            OP_SHR: ex1.res = big_shift ? '0 : (d >> shamt);
            default: ex1.wr = 1'b0;
        endcase

        // Flag source: result when written, difference for compare, else dst
        if (ex1.wr)
        begin
            ex1.fsrc = ex1.res;
        end
        else if (op_t'(op_in.func) == OP_CMP)
        begin
            ex1.fsrc = diff;
        end
        else
        begin
            ex1.fsrc = d;
        end
    end

endmodule

### design/szalu_merge.sv
// Second execute stage: sums the partial products and picks the halves.
// Uses szalu_pkg types; fed from the registered first stage.
module szalu_merge (
    input  szalu_pkg::ex1_t ex1,
    output szalu_pkg::ex2_t ex2
);
    import szalu_pkg::*;

    logic [PROD_WIDTH-1:0] prod;
    logic [DATA_WIDTH-1:0] m;
    logic [DATA_WIDTH-1:0] prod_lo;
    logic [DATA_WIDTH-1:0] prod_hi;

    // Full product from the four partial products
    assign prod = {ex1.pp_hh, {DATA_WIDTH{1'b0}}}
                + {{HALF_WIDTH{1'b0}}, ex1.pp_lh, {HALF_WIDTH{1'b0}}}
                + {{HALF_WIDTH{1'b0}}, ex1.pp_hl, {HALF_WIDTH{1'b0}}}
                + {{DATA_WIDTH{1'b0}}, ex1.pp_ll};

    assign m       = width_mask(ex1.wcode);
    assign prod_lo = prod[DATA_WIDTH-1:0] & m;

    // Upper half sits just above the operand width
    always_comb
    begin
        unique case (ex1.wcode)
            W_8:     prod_hi = DATA_WIDTH'(prod[15:8]);
            W_16:    prod_hi = DATA_WIDTH'(prod[31:16]);
            W_32:    prod_hi = DATA_WIDTH'(prod[63:32]);
            default: prod_hi = prod[PROD_WIDTH-1:DATA_WIDTH];
        endcase
    end

    always_comb
    begin
        ex2.wcode = ex1.wcode;
        ex2.wr    = ex1.wr;
        ex2.wh    = ex1.is_mul;
        ex2.res   = ex1.is_mul ? prod_lo : ex1.res;
        ex2.high  = ex1.is_mul ? prod_hi : '0;
        ex2.fsrc  = ex1.is_mul ? prod_lo : ex1.fsrc;
    end

endmodule

### design/sized_integer_alu_with_flags.sv
// Sized integer ALU with zero, sign and even flags, 8/16/32/64-bit operands.
// Pipeline: input register, two execute stages split at the 32x32 partial
// products, output register.
// Throughput: one item per cycle while the output is not stalled; each stage moves when the next is free.
// Reset: rst_n asynchronous, clears all stage valid bits; data is not reset.
// Depends on szalu_pkg, szalu_ops, szalu_merge.
module sized_integer_alu_with_flags (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // func[3:0], width_code[5:4], src_value[69:6], dst_value[133:70], zero pad
    input  logic [szalu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_value[63:0], high_part[127:64], writes_result[128],
    // writes_high[129], zero_flag[130], sign_flag[131], even_flag[132], pad
    output logic [szalu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import szalu_pkg::*;

    opnd_t                  opnd_next, opnd_reg;
    ex1_t                   ex1_next, ex1_reg;
    ex2_t                   ex2_next, ex2_reg;
    logic [OUT_BITS-1:0]    out_next, out_reg;
    logic                   in_v_reg, ex1_v_reg, ex2_v_reg, out_v_reg;
    logic                   in_adv, ex1_adv, ex2_adv, out_adv;
    logic                   zero_f, sign_f, even_f;
    logic [DATA_WIDTH-1:0]  in_mask;

    // Stage advance: a stage loads when it is empty or its item moves on
    assign out_adv = !out_v_reg || m_axis_tready;
    assign ex2_adv = !ex2_v_reg || out_adv;
    assign ex1_adv = !ex1_v_reg || ex2_adv;
    assign in_adv  = !in_v_reg  || ex1_adv;
    assign s_axis_tready = in_adv;

    // Unpack and mask operands to the selected width
    always_comb
    begin
        opnd_next.func  = s_axis_tdata[FUNC_WIDTH-1:0];
        opnd_next.wcode = wcode_t'(s_axis_tdata[FUNC_WIDTH +: WCODE_WIDTH]);
        in_mask         = width_mask(opnd_next.wcode);
        opnd_next.src   = s_axis_tdata[FUNC_WIDTH+WCODE_WIDTH +: DATA_WIDTH] & in_mask;
        opnd_next.dst   = s_axis_tdata[FUNC_WIDTH+WCODE_WIDTH+DATA_WIDTH +: DATA_WIDTH]
                        & in_mask;
    end

    szalu_ops u_ops (
        .op_in (opnd_reg),
        .ex1   (ex1_next)
    );

    szalu_merge u_merge (
        .ex1 (ex1_reg),
        .ex2 (ex2_next)
    );

    // Flags from the flag source at operand width
    always_comb
    begin
        zero_f = (ex2_reg.fsrc == '0);
        even_f = !ex2_reg.fsrc[0];
        unique case (ex2_reg.wcode)
            W_8:     sign_f = ex2_reg.fsrc[7];
            W_16:    sign_f = ex2_reg.fsrc[15];
            W_32:    sign_f = ex2_reg.fsrc[31];
            default: sign_f = ex2_reg.fsrc[DATA_WIDTH-1];
        endcase
        out_next = {even_f, sign_f, zero_f, ex2_reg.wh, ex2_reg.wr,
                    ex2_reg.high, ex2_reg.res};
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            ex1_v_reg <= 1'b0;
            ex2_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_v_reg <= s_axis_tvalid;
            end
            if (ex1_adv)
            begin
                ex1_v_reg <= in_v_reg;
            end
            if (ex2_adv)
            begin
                ex2_v_reg <= ex1_v_reg;
            end
            if (out_adv)
            begin
                out_v_reg <= ex2_v_reg;
            end
        end
    end

    // Stage payload registers
    always_ff @(posedge clk)
    begin
        if (in_adv && s_axis_tvalid)
        begin
            opnd_reg <= opnd_next;
        end
        if (ex1_adv && in_v_reg)
        begin
            ex1_reg <= ex1_next;
        end
        if (ex2_adv && ex1_v_reg)
        begin
            ex2_reg <= ex2_next;
        end
        if (out_adv && ex2_v_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_reg);

endmodule

### design/szalu_checker.sv
// Port-level checks for the sized integer ALU, bound to the top level.
// Uses szalu_pkg for field widths; sees only the top-level ports.
module szalu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [szalu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [szalu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import szalu_pkg::*;

    logic [DATA_WIDTH-1:0] res_f;
    logic [DATA_WIDTH-1:0] high_f;
    logic                  wr_f, wh_f, zero_f, even_f;

    assign res_f  = m_axis_tdata[DATA_WIDTH-1:0];
    assign high_f = m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign wr_f   = m_axis_tdata[2*DATA_WIDTH];
    assign wh_f   = m_axis_tdata[2*DATA_WIDTH+1];
    assign zero_f = m_axis_tdata[2*DATA_WIDTH+2];
    assign even_f = m_axis_tdata[2*DATA_WIDTH+4];

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // Multiply writes both destinations
    a_mul_writes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && wh_f |-> wr_f)
        else $error("high part written without result");

    // Only multiply produces a high part
    a_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !wh_f |-> high_f == '0)
        else $error("high part nonzero outside multiply");

    // Compare and unknown opcodes leave the result at zero
    a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !wr_f |-> res_f == '0)
        else $error("result nonzero without write");

    // Flags follow the written result
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && wr_f |-> (zero_f == (res_f == '0)) && (even_f == !res_f[0]))
        else $error("flags disagree with written result");

endmodule

bind sized_integer_alu_with_flags szalu_checker u_szalu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb.sv
// Testbench for sized_integer_alu_with_flags: directed and random ALU items with an
// independent predictor, a result scoreboard and random stalls on both streams.
// Depends on szalu_pkg and the sized_integer_alu_with_flags RTL.
`timescale 1ns / 100ps

module tb;
    import szalu_pkg::*;

    // Opcodes that do nothing
    localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED_FIRST = 4'd12;
    localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED_LAST  = 4'd15;
    localparam int RANDOM_ITEMS   = 600;
    localparam int QUIET_LIMIT    = 2000;   // cycles with no item accepted or delivered
    localparam int DRAIN_CYCLES   = 20;

    // One expected result item
    typedef struct packed {
        logic [DATA_WIDTH-1:0] result_value;
        logic [DATA_WIDTH-1:0] high_part;
        logic                  writes_result;
        logic                  writes_high;
        logic                  zero_flag;
        logic                  sign_flag;
        logic                  even_flag;
    } alu_result_t;

    // Computes ALU results for accepted items and checks them in order
    class alu_scoreboard;
        alu_result_t pending_results[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function alu_result_t predict(logic [FUNC_WIDTH-1:0] func, wcode_t wc,
                                      logic [DATA_WIDTH-1:0] src_raw,
                                      logic [DATA_WIDTH-1:0] dst_raw);
            int unsigned             w;
            logic [DATA_WIDTH-1:0]   m;
            logic [DATA_WIDTH-1:0]   s;
            logic [DATA_WIDTH-1:0]   d;
            logic [DATA_WIDTH-1:0]   fsrc;
            logic [PROD_WIDTH-1:0]   prod;
            alu_result_t             r;
            w = 8 << wc;
            m = (w == DATA_WIDTH) ? '1 : ((64'd1 << w) - 64'd1);
            s = src_raw & m;
            d = dst_raw & m;
            r = '0;
            r.writes_result = 1'b1;
            prod = {64'd0, s} * {64'd0, d};
            case (func)
                OP_MOV: r.result_value = s;
                OP_ADD: r.result_value = (d + s) & m;
                OP_CMP: r.writes_result = 1'b0;
                OP_SUB: r.result_value = (d - s) & m;
                OP_MUL:
                begin
                    r.result_value = prod[DATA_WIDTH-1:0] & m;
                    prod = prod >> w;
                    r.high_part = prod[DATA_WIDTH-1:0] & m;
                    r.writes_high = 1'b1;
                end
                OP_NEG: r.result_value = (~d + 64'd1) & m;
                OP_AND: r.result_value = s & d;
                OP_OR:  r.result_value = s | d;
                OP_XOR: r.result_value = s ^ d;
                OP_NOT: r.result_value = ~d & m;
                OP_SHL: r.result_value = (s >= DATA_WIDTH) ? '0 : ((d << s[5:0]) & m);
                OP_SHR: r.result_value = (s >= DATA_WIDTH) ? '0 : (d >> s[5:0]);
                default: r.writes_result = 1'b0;
            endcase
            // Flags follow the written value, the difference for compare,
            // or the destination when nothing is written
            if (r.writes_result)
                fsrc = r.result_value;
            else if (func == OP_CMP)
                fsrc = (d - s) & m;
            else
                fsrc = d;
            r.zero_flag = (fsrc == '0);
            r.sign_flag = fsrc[w-1];
            r.even_flag = ~fsrc[0];
            return r;
        endfunction

        function void note_input(logic [IN_TDATA_W-1:0] item);
            pending_results.push_back(predict(item[3:0], wcode_t'(item[5:4]),
                                              item[69:6], item[133:70]));
        endfunction

        function void compare_field(string name, logic [DATA_WIDTH-1:0] want,
                                    logic [DATA_WIDTH-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, actual %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] item);
            alu_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: %h", item);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_value", want.result_value, item[63:0]);
            compare_field("high_part", want.high_part, item[127:64]);
            compare_field("writes_result", 64'(want.writes_result), 64'(item[128]));
            compare_field("writes_high", 64'(want.writes_high), 64'(item[129]));
            compare_field("zero_flag", 64'(want.zero_flag), 64'(item[130]));
            compare_field("sign_flag", 64'(want.sign_flag), 64'(item[131]));
            compare_field("even_flag", 64'(want.even_flag), 64'(item[132]));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    alu_scoreboard sb = new();
    bit            idle_on = 1'b1;
    int            quiet_cycles = 0;

    sized_integer_alu_with_flags dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none while idling is off
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Edge-heavy 64-bit operand
    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return 64'($urandom_range(0, 3));
            3: return 64'h8000_0000_0000_0000 >> $urandom_range(0, 63);
            4: return ~(64'h8000_0000_0000_0000 >> $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Accept and result monitor, plus the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: random stalls between bursts of ready
    initial
    begin
        int gap;
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // Present one item and hold it until accepted
    task automatic send_item(input logic [FUNC_WIDTH-1:0] func, input wcode_t wc,
                             input logic [DATA_WIDTH-1:0] src,
                             input logic [DATA_WIDTH-1:0] dst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({dst, src, wc, func});
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random_items(input int count);
        logic [FUNC_WIDTH-1:0] func;
        logic [DATA_WIDTH-1:0] src;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                func = FUNC_WIDTH'($urandom_range(OP_MOV, OP_SHR));
            else
                func = FUNC_WIDTH'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
            // Shifts mostly get amounts from 0 to 70, spanning every operand width
            if ((func == OP_SHL || func == OP_SHR) && $urandom_range(0, 3) != 0)
                src = 64'($urandom_range(0, 70));
            else
                src = pick_operand();
            send_item(func, wcode_t'($urandom_range(0, 3)), src, pick_operand());
        end
    endtask

    task automatic send_directed_items();
        send_item(OP_MOV, W_64, '1, 64'h0123_4567_89AB_CDEF);
        send_item(OP_MOV, W_8, 64'hFFFF_FFFF_FFFF_FF7E, '1);
        send_item(OP_ADD, W_8, 64'h01, 64'hFF);                     // wraps to zero
        send_item(OP_ADD, W_64, '1, '1);
        send_item(OP_CMP, W_16, 64'h1234, 64'hFFFF_0000_0000_1234); // equal
        send_item(OP_CMP, W_32, 64'h5, 64'h3);                      // negative difference
        send_item(OP_SUB, W_64, 64'h1, 64'h0);
        send_item(OP_MUL, W_64, '1, '1);
        send_item(OP_MUL, W_8, 64'hFF, 64'hFF);
        send_item(OP_MUL, W_32, 64'hFFFF_FFFF, 64'h8000_0001);
        send_item(OP_MUL, W_16, 64'h0, '1);
        send_item(OP_NEG, W_16, 64'h0, 64'h0);
        send_item(OP_NEG, W_8, 64'h0, 64'h80);
        send_item(OP_AND, W_32, '1, 64'hAAAA_AAAA_5555_5555);
        send_item(OP_OR, W_16, 64'h00F0, 64'h0F01);
        send_item(OP_XOR, W_64, '1, 64'h5555_5555_5555_5555);
        send_item(OP_NOT, W_32, 64'h0, 64'h0);
        send_item(OP_SHL, W_64, 64'd63, 64'h1);
        send_item(OP_SHL, W_8, 64'h140, 64'hFF);                    // masked amount is 64
        send_item(OP_SHR, W_64, 64'd100, '1);                       // amount past 63
        send_item(OP_SHR, W_8, 64'hF07, 64'h80);
        for (int k = 0; k <= FUNC_UNUSED_LAST - FUNC_UNUSED_FIRST; k++)
            send_item(FUNC_UNUSED_FIRST + FUNC_WIDTH'(k), wcode_t'(k),
                      '1, 64'h8000_0000_0000_0081 << k);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed_items();
        // Random part, with a stretch of back-to-back traffic in the middle
        send_random_items(RANDOM_ITEMS * 2 / 5);
        idle_on = 1'b0;
        send_random_items(RANDOM_ITEMS / 5);
        idle_on = 1'b1;
        send_random_items(RANDOM_ITEMS * 2 / 5);
        s_axis_tvalid <= 1'b0;

        // Drain, then watch for stray results
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
